[hdl/atkr_pkg.sv]
// atkr_pkg: shared types and constants for the axis-to-key repeat block.
// No dependencies; imported by every module of the block.
package atkr_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int KEY_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam int REQ_W     = 2 * SAMPLE_W + TIME_W;   // 64, whole bytes
   localparam int RSP_W     = 8;                       // key code padded to a byte

   // key codes
   localparam logic [KEY_W-1:0] KEY_LEFT  = 2'd0;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 2'd1;
   localparam logic [KEY_W-1:0] KEY_UP    = 2'd2;
   localparam logic [KEY_W-1:0] KEY_DOWN  = 2'd3;

   // axis direction, two's complement
   localparam logic [1:0] DIR_REST = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd3;

   localparam logic [TIME_W-1:0] MARK_IDLE = 32'h7FFF_FFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELAX    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd3;

   // reset values: 0.5 and 0.35 of full scale, 400 ms, 200 ms
   localparam logic [14:0] TRIGGER_RST  = 15'd16383;
   localparam logic [15:0] RELAX_RST    = 16'd11469;
   localparam logic [15:0] DELAY_RST    = 16'd400;
   localparam logic [15:0] INTERVAL_RST = 16'd200;

   typedef struct packed {
      logic [14:0] trigger_level;
      logic [15:0] relax_level;
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        dir;
      logic              repeating;
      logic [TIME_W-1:0] mark;
   } axis_state_type;

   typedef struct packed {
      logic             fire;
      logic [KEY_W-1:0] code;
   } axis_event_type;

endpackage

[hdl/atkr_axis.sv]
// atkr_axis: one stick axis, hysteresis plus typematic repeat, pure logic.
// Depends on atkr_pkg.
module atkr_axis (
   input  atkr_pkg::cfg_type                 cfg,
   input  logic signed [atkr_pkg::SAMPLE_W-1:0] sample,
   input  logic [atkr_pkg::TIME_W-1:0]       now_ms,
   input  logic                              is_y,
   input  atkr_pkg::axis_state_type          cur,
   output atkr_pkg::axis_state_type          nxt,
   output atkr_pkg::axis_event_type          evt
);
   import atkr_pkg::*;

   logic signed [SAMPLE_W:0] s_ext;
   logic signed [SAMPLE_W:0] t_ext;
   logic [SAMPLE_W:0]        mag;
   logic [TIME_W-1:0]        elapsed;
   logic [KEY_W-1:0]         neg_key;
   logic [KEY_W-1:0]         pos_key;

   assign s_ext   = {sample[SAMPLE_W-1], sample};
   assign t_ext   = {2'b00, cfg.trigger_level};
   assign mag     = sample[SAMPLE_W-1] ? 17'(-s_ext) : 17'(s_ext);
   assign elapsed = now_ms - cur.mark;
   assign neg_key = is_y ? KEY_UP : KEY_LEFT;
   assign pos_key = is_y ? KEY_DOWN : KEY_RIGHT;

   always_comb begin
      nxt      = cur;
      evt.fire = 1'b0;
      evt.code = pos_key;
      if (cur.dir != DIR_REST) begin
         if (mag < {1'b0, cfg.relax_level}) begin
            nxt.dir       = DIR_REST;
            nxt.repeating = 1'b0;
            nxt.mark      = MARK_IDLE;
         end else if ((cur.repeating && elapsed > {16'd0, cfg.repeat_interval_ms}) ||
                      elapsed > {16'd0, cfg.repeat_delay_ms}) begin
            // interval test first, delay test as fallback; both refire
            if (!(cur.repeating && elapsed > {16'd0, cfg.repeat_interval_ms}))
               nxt.repeating = 1'b1;
            nxt.mark = now_ms;
            // unused code 2 refreshes the mark but sends nothing
            if (cur.dir == DIR_NEG) begin
               evt.fire = 1'b1;
               evt.code = neg_key;
            end else if (cur.dir == DIR_POS) begin
               evt.fire = 1'b1;
               evt.code = pos_key;
            end
         end
      end else if (s_ext < -t_ext) begin
         nxt.dir  = DIR_NEG;
         nxt.mark = now_ms;
         evt.fire = 1'b1;
         evt.code = neg_key;
      end else if (s_ext > t_ext) begin
         nxt.dir  = DIR_POS;
         nxt.mark = now_ms;
         evt.fire = 1'b1;
         evt.code = pos_key;
      end
   end

endmodule

[hdl/axis_to_key_repeat.sv]
// axis_to_key_repeat: joystick X/Y samples to direction-key words with repeat.
// Path: a request word passes the input register, then the result buffer, before
// its first key word is offered on rsp; a full buffer holds it in the input register.
// Throughput: one request per cycle while the buffer has room; a poll that fires both
// axes fills both slots of the two-slot result buffer, so the rate is set by rsp drain.
// Reset (synchronous, high): axes at rest, registers at defaults, buffers empty.
// Depends on atkr_pkg and atkr_axis.
module axis_to_key_repeat (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = x_sample[15:0], y_sample[31:16], now_ms[63:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [atkr_pkg::REQ_W-1:0]        req_tdata,
   input  logic                              req_tuser,   // enabled
   // response: tdata = key_code[1:0], zeros above
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [atkr_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast,   // last_event
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [atkr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [atkr_pkg::CSR_W-1:0]        csr_data
);
   import atkr_pkg::*;

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;   // never stalls; a write lands in cfg_ff at the next clock edge

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIGGER:  cfg_in.trigger_level      = csr_data[14:0];
            CSR_RELAX:    cfg_in.relax_level        = csr_data;
            CSR_DELAY:    cfg_in.repeat_delay_ms    = csr_data;
            CSR_INTERVAL: cfg_in.repeat_interval_ms = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level      <= TRIGGER_RST;
         cfg_ff.relax_level        <= RELAX_RST;
         cfg_ff.repeat_delay_ms    <= DELAY_RST;
         cfg_ff.repeat_interval_ms <= INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- input register ----------------
   logic              req_valid_ff;
   logic [REQ_W-1:0]  req_data_ff;
   logic              req_en_ff;
   logic              commit;

   // stage frees up in the same cycle it hands its events to the buffer
   assign req_tready = !req_valid_ff || commit;

   always_ff @(posedge clock) begin
      if (reset)
         req_valid_ff <= 1'b0;
      else if (req_tready)
         req_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_tdata;
         req_en_ff   <= req_tuser;
      end
   end

   // ---------------- per-axis state and update ----------------
   axis_state_type x_ff, x_in, y_ff, y_in;
   axis_event_type x_evt, y_evt;

   atkr_axis u_axis_x (
      .cfg    (cfg_ff),
      .sample (req_data_ff[SAMPLE_W-1:0]),
      .now_ms (req_data_ff[REQ_W-1:2*SAMPLE_W]),
      .is_y   (1'b0),
      .cur    (x_ff),
      .nxt    (x_in),
      .evt    (x_evt)
   );

   atkr_axis u_axis_y (
      .cfg    (cfg_ff),
      .sample (req_data_ff[2*SAMPLE_W-1:SAMPLE_W]),
      .now_ms (req_data_ff[REQ_W-1:2*SAMPLE_W]),
      .is_y   (1'b1),
      .cur    (y_ff),
      .nxt    (y_in),
      .evt    (y_evt)
   );

   // disabled polls leave state alone and fire nothing
   logic      fire_x, fire_y;
   logic      upd;
   logic [1:0] n_new;

   assign fire_x = req_en_ff && x_evt.fire;
   assign fire_y = req_en_ff && y_evt.fire;
   assign n_new  = {1'b0, fire_x} + {1'b0, fire_y};
   assign upd    = commit && req_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '{dir: DIR_REST, repeating: 1'b0, mark: MARK_IDLE};
         y_ff <= '{dir: DIR_REST, repeating: 1'b0, mark: MARK_IDLE};
      end else if (upd) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // ---------------- two-slot result buffer ----------------
   logic [KEY_W-1:0] slot_code_ff [2];
   logic [KEY_W-1:0] slot_code_in [2];
   logic             slot_last_ff [2];
   logic             slot_last_in [2];
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;
   logic [1:0]       held;
   logic [2:0]       total;
   logic [KEY_W-1:0] e0_code, e1_code;

   assign pop   = rsp_tvalid && rsp_tready;
   assign held  = cnt_ff - {1'b0, pop};
   assign total = {1'b0, held} + {1'b0, n_new};

   // fits if what stays plus the new words is at most two
   assign commit = req_valid_ff && (total <= 3'd2);

   // X word goes first; the last word of the poll carries tlast
   assign e0_code = fire_x ? x_evt.code : y_evt.code;
   assign e1_code = y_evt.code;

   always_comb begin
      slot_code_in = slot_code_ff;
      slot_last_in = slot_last_ff;
      if (pop) begin
         slot_code_in[0] = slot_code_ff[1];
         slot_last_in[0] = slot_last_ff[1];
      end
      if (commit && n_new != 2'd0) begin
         slot_code_in[held[0]] = e0_code;
         slot_last_in[held[0]] = (n_new == 2'd1);
         if (n_new == 2'd2) begin
            slot_code_in[1] = e1_code;   // held is zero here
            slot_last_in[1] = 1'b1;
         end
      end
      cnt_in = commit ? total[1:0] : held;
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= 2'd0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      slot_code_ff <= slot_code_in;
      slot_last_ff <= slot_last_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {{(RSP_W-KEY_W){1'b0}}, slot_code_ff[0]};
   assign rsp_tlast  = slot_last_ff[0];

endmodule

[hdl/atkr_checker.sv]
// atkr_checker: port-level checks on axis_to_key_repeat, bound to the top.
// Depends on atkr_pkg.
module atkr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [atkr_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                           rsp_tlast
);
   import atkr_pkg::*;

   // a stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // padding above the key code is zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:KEY_W] == '0)
      else $error("rsp padding not zero");

   // a non-last word is always followed at once by its partner
   a_pair_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second word of a poll missing");

   // only an X key (left or right) can lead a two-word poll
   a_x_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[KEY_W-1:0] == KEY_LEFT ||
                                    rsp_tdata[KEY_W-1:0] == KEY_RIGHT))
      else $error("Y word ahead of X word");

endmodule

bind axis_to_key_repeat atkr_checker u_atkr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/testbench.sv]
// testbench: self-checking bench for axis_to_key_repeat (stick samples to key words).
// Holds its own per-axis hysteresis/repeat predictor in a small scoreboard class.
// Depends on atkr_pkg and the axis_to_key_repeat RTL.
`timescale 1ns / 100ps

module testbench;
   import atkr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYC  = 10;     // outlasts the input register and result buffer, covers polls that fire nothing

   // Scoreboard: predicts key words per accepted poll and checks rsp words in order.
   class key_event_board;
      logic [14:0] trigger;
      logic [15:0] relax;
      logic [15:0] delay_ms;
      logic [15:0] interval_ms;
      logic [1:0]  dir[2];
      bit          rep[2];
      logic [31:0] mark[2];
      logic [2:0]  key_q[$];             // {key_code, last_event}
      int          errors;

      function new();
         trigger     = TRIGGER_RST;
         relax       = RELAX_RST;
         delay_ms    = DELAY_RST;
         interval_ms = INTERVAL_RST;
         for (int a = 0; a < 2; a++) begin
            dir[a]  = DIR_REST;
            rep[a]  = 0;
            mark[a] = MARK_IDLE;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_TRIGGER:  trigger     = val[14:0];
            CSR_RELAX:    relax       = val;
            CSR_DELAY:    delay_ms    = val;
            CSR_INTERVAL: interval_ms = val;
            default: ;
         endcase
      endfunction

      // One axis: release, repeat or fresh trigger.
      function void step_axis(int a, logic signed [15:0] s, logic [31:0] now,
                              logic [1:0] neg_key, logic [1:0] pos_key,
                              output bit fire, output logic [1:0] key);
         int          sv;
         int          mag;
         int          th;
         int          rl;
         logic [31:0] age;
         sv   = s;
         mag  = (sv < 0) ? -sv : sv;   // -32768 gives 32768, no overflow in 32 bits
         th   = trigger;
         rl   = relax;
         age  = now - mark[a];
         fire = 0;
         key  = neg_key;
         if (dir[a] != DIR_REST) begin
            if (mag < rl) begin
               dir[a]  = DIR_REST;
               rep[a]  = 0;
               mark[a] = MARK_IDLE;
               return;
            end
            // interval test only once repeating; delay test is the fallback
            if (rep[a] && age > {16'd0, interval_ms}) begin
               mark[a] = now;
               fire    = 1;
            end else if (age > {16'd0, delay_ms}) begin
               rep[a]  = 1;
               mark[a] = now;
               fire    = 1;
            end
            if (dir[a] == DIR_POS) key = pos_key;
            else if (dir[a] != DIR_NEG) fire = 0;
         end else if (sv < -th) begin
            dir[a]  = DIR_NEG;
            mark[a] = now;
            fire    = 1;
         end else if (sv > th) begin
            dir[a]  = DIR_POS;
            mark[a] = now;
            fire    = 1;
            key     = pos_key;
         end
      endfunction

      function void note_poll(logic signed [15:0] xs, logic signed [15:0] ys,
                              logic [31:0] now, bit en);
         bit         fx;
         bit         fy;
         logic [1:0] kx;
         logic [1:0] ky;
         if (!en) return;
         step_axis(0, xs, now, KEY_LEFT, KEY_RIGHT, fx, kx);
         step_axis(1, ys, now, KEY_UP, KEY_DOWN, fy, ky);
         if (fx) key_q.push_back({kx, !fy});
         if (fy) key_q.push_back({ky, 1'b1});
      endfunction

      function void check_key(logic [RSP_W-1:0] data, logic last);
         logic [2:0] want;
         if (key_q.size() == 0) begin
            $error("unexpected key word: key_code %0d last_event %0d", data[1:0], last);
            errors++;
            return;
         end
         want = key_q.pop_front();
         if (data[1:0] !== want[2:1]) begin
            $error("key_code: expected %0d, actual %0d", want[2:1], data[1:0]);
            errors++;
         end
         if (data[RSP_W-1:2] !== '0) begin
            $error("tdata pad: expected 0, actual %0h", data[RSP_W-1:2]);
            errors++;
         end
         if (last !== want[0]) begin
            $error("last_event: expected %0d, actual %0d", want[0], last);
            errors++;
         end
      endfunction

      function int pending();
         return key_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   key_event_board board = new();
   int             cycles = 0;
   bit             no_idle = 0;      // phase-wide stretch with no gaps and no stalls
   logic [31:0]    tick_ms = 0;      // running poll timestamp

   axis_to_key_repeat dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result monitor: sample at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_key(rsp_tdata, rsp_tlast);
   end

   // Result backpressure, updated on the falling edge
   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
            stall      = pick_gap();
         end
      end
   end

   task automatic send_poll(logic [15:0] xs, logic [15:0] ys, logic [31:0] now, bit en);
      int gap;
      req_tdata  = {now, ys, xs};
      req_tuser  = en;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      board.note_poll(xs, ys, now, en);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Leaves csr_valid high; load_config drops it after the last write.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic load_config(logic [15:0] trig, logic [15:0] rlx,
                              logic [15:0] dly, logic [15:0] ivl);
      csr_write(CSR_TRIGGER, trig);
      csr_write(CSR_RELAX, rlx);
      csr_write(CSR_DELAY, dly);
      csr_write(CSR_INTERVAL, ivl);
      csr_valid = 0;
   endtask

   // Drain: all expected words seen, then enough cycles for silent polls in flight.
   task automatic settle();
      req_tvalid = 0;
      while (board.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // Sample level aimed at the interesting thresholds of the current setting.
   function automatic logic [15:0] pick_level();
      int th;
      int rl;
      int v;
      int k;
      th = board.trigger;
      rl = board.relax;
      k  = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 32767;
         2: v = -32768;
         3: v = th + k - 1;
         4: v = rl + k - 1;
         8: v = $urandom;
         9: v = $urandom_range(0, rl);
         default: v = th + 1 + int'($urandom_range(0, 32767 - th));
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return 16'(v);
   endfunction

   // Time step: small, straddling delay or interval, or a big jump (wraps now_ms).
   function automatic logic [31:0] step_ms();
      int k;
      k = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
         7, 8, 9:    return 32'(board.delay_ms) + k - 1;
         10, 11, 12: return 32'(board.interval_ms) + k - 1;
         13, 14, 15, 16, 17: return $urandom_range(0, 1200);
         18: return $urandom_range(0, 70000);
         19: return $urandom;
         default: return $urandom_range(0, 60);
      endcase
   endfunction

   // Strokes: each axis held at a level for a few polls, with some noise.
   task automatic run_random(int count);
      int          hold;
      logic [15:0] xt;
      logic [15:0] yt;
      logic [15:0] xs;
      logic [15:0] ys;
      hold = 0;
      xt   = 0;
      yt   = 0;
      for (int i = 0; i < count; i++) begin
         if (hold == 0) begin
            hold = $urandom_range(2, 12);
            if ($urandom_range(0, 1)) xt = pick_level();
            if ($urandom_range(0, 1)) yt = pick_level();
         end
         hold--;
         xs = xt;
         ys = yt;
         case ($urandom_range(0, 9))
            0: xs = 16'($urandom);
            1: ys = 16'($urandom);
            2: xs = xs ^ 16'($urandom_range(0, 15));
            default: ;
         endcase
         tick_ms += step_ms();
         send_poll(xs, ys, tick_ms, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      csr_valid  = 0;
      csr_index  = CSR_TRIGGER;
      csr_data   = '0;
      repeat (4) @(negedge clock);
      reset = 0;

      // Directed, reset setting: thresholds, order, delay then interval repeats
      send_poll(16'sd32767, -16'sd32768, 32'd1000, 0);     // disabled poll
      send_poll(16'sd16383, -16'sd16383, 32'd1000, 1);     // exactly at trigger
      send_poll(16'sd16384, -16'sd16384, 32'd1010, 1);     // right then up
      send_poll(16'sd16384, -16'sd16384, 32'd1410, 1);     // delay not yet exceeded
      send_poll(16'sd16384, -16'sd16384, 32'd1411, 1);     // first repeat
      send_poll(16'sd16384, -16'sd16384, 32'd1611, 1);     // interval not exceeded
      send_poll(16'sd32767, -16'sd32768, 32'd1612, 1);     // interval repeat
      send_poll(16'sd11469, -16'sd11469, 32'd1700, 1);     // at relax: held
      send_poll(16'sd11468, -16'sd11468, 32'd1701, 1);     // release, silent
      send_poll(-16'sd16384, 16'sd16384, 32'd1702, 1);     // left then down
      send_poll(-16'sd32768, 16'sd0, 32'd1703, 1);         // y released
      send_poll(-16'sd32768, 16'sd32767, 32'hFFFF_FF00, 1);
      send_poll(-16'sd32768, 16'sd32767, 32'h0000_0010, 1); // age wraps past zero
      send_poll(16'sd0, 16'sd0, 32'h0000_1000, 0);         // disabled: state held
      send_poll(-16'sd32768, 16'sd32767, 32'h0000_1001, 1);
      settle();

      // Short delay, long interval: the delay path fires the first repeat
      load_config(TRIGGER_RST, RELAX_RST, 16'd3, 16'd100);
      send_poll(16'sd20000, 16'sd20000, 32'd5000, 1);
      send_poll(16'sd20000, 16'sd20000, 32'd5002, 1);
      send_poll(16'sd20000, 16'sd20000, 32'd5006, 1);
      send_poll(16'sd0, 16'sd0, 32'd5010, 1);
      settle();

      // Low extremes: trigger zero, relax zero, no delays
      load_config(16'd0, 16'd0, 16'd0, 16'd0);
      send_poll(16'sd0, 16'sd0, 32'd6000, 1);
      send_poll(16'sd1, -16'sd1, 32'd6001, 1);
      send_poll(16'sd0, 16'sd0, 32'd6001, 1);
      send_poll(16'sd0, 16'sd0, 32'd6002, 1);
      tick_ms = 32'd6002;
      run_random(110);
      settle();

      // High extremes; bit 15 of the trigger write is dropped by the block
      load_config(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF);
      run_random(90);
      settle();

      // Reset values again, no idling on either side
      no_idle = 1;
      load_config(16'(TRIGGER_RST), RELAX_RST, DELAY_RST, INTERVAL_RST);
      run_random(130);
      settle();
      no_idle = 0;

      for (int p = 0; p < 4; p++) begin
         load_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 800)), 16'($urandom_range(0, 800)));
         run_random(75);
         settle();
      end

      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
